// ===== hdl/handle_pool_allocator_unit_assert.svh =====
// Assertion macros used by the handle pool allocator checker.
`ifndef HANDLE_POOL_ALLOCATOR_UNIT_ASSERT_SVH
`define HANDLE_POOL_ALLOCATOR_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define HPA_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("handle pool allocator check failed");

// Consequent must hold in the cycle after the antecedent.
`define HPA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("handle pool allocator check failed");

`endif

// ===== hdl/hpa_pkg.sv =====
// Shared types and codes of the handle pool allocator.
package hpa_pkg;

  localparam int unsigned HANDLE_W = 4;
  localparam int unsigned STATUS_W = 2;

  localparam logic FUNC_ALLOC   = 1'b0;
  localparam logic FUNC_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_BAD    = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;  // capture the request fields
    logic commit;    // update pool state and load the result register
  } cmd_t;

endpackage

// ===== hdl/hpa_datapath.sv =====
// Datapath of the handle pool allocator: free ring, pointers, active bitmap, result register.
module hpa_datapath #(
  parameter int unsigned POOL_SIZE = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  hpa_pkg::cmd_t                       cmd_i,
  input  logic                                func_i,
  input  logic [hpa_pkg::HANDLE_W-1:0]        handle_i,
  output logic [hpa_pkg::STATUS_W-1:0]        status_o,
  output logic [hpa_pkg::HANDLE_W-1:0]        granted_handle_o
);

  localparam int unsigned IDX_W = $clog2(POOL_SIZE);
  localparam int unsigned CNT_W = $clog2(POOL_SIZE + 1);
  localparam int unsigned HW    = (IDX_W > hpa_pkg::HANDLE_W) ? IDX_W : hpa_pkg::HANDLE_W;
  localparam int unsigned CW    = HW + 1;

  // Ring storage; an entry never written reads as its own index.
  logic [IDX_W-1:0]     ring_q [POOL_SIZE];
  logic [POOL_SIZE-1:0] written_q;
  logic [POOL_SIZE-1:0] active_q;
  logic [IDX_W-1:0]     head_q;
  logic [IDX_W-1:0]     tail_q;
  logic [CNT_W-1:0]     count_q;

  logic [IDX_W-1:0]     rd_data_q;
  logic [IDX_W-1:0]     rd_idx_q;
  logic                 rd_written_q;

  logic                          func_q;
  logic [hpa_pkg::HANDLE_W-1:0]  handle_q;
  logic [hpa_pkg::STATUS_W-1:0]  status_q;
  logic [hpa_pkg::HANDLE_W-1:0]  granted_q;

  logic [IDX_W-1:0]              grant_idx;
  logic [IDX_W-1:0]              rel_idx;
  logic                          rel_in_range;
  logic                          alloc_ok;
  logic                          rel_ok;
  logic [hpa_pkg::STATUS_W-1:0]  status_d;
  logic [hpa_pkg::HANDLE_W-1:0]  granted_d;
  logic [IDX_W-1:0]              head_next;
  logic [IDX_W-1:0]              tail_next;

  assign grant_idx    = rd_written_q ? rd_data_q : rd_idx_q;
  assign rel_idx      = IDX_W'(handle_q);
  assign rel_in_range = CW'(handle_q) < CW'(POOL_SIZE);

  assign alloc_ok = (func_q == hpa_pkg::FUNC_ALLOC) && (count_q != '0);
  assign rel_ok   = (func_q == hpa_pkg::FUNC_RELEASE) && rel_in_range &&
                    active_q[rel_idx] && (count_q != CNT_W'(POOL_SIZE));

  assign head_next = (head_q == IDX_W'(POOL_SIZE - 1)) ? '0 : head_q + 1'b1;
  assign tail_next = (tail_q == IDX_W'(POOL_SIZE - 1)) ? '0 : tail_q + 1'b1;

  always_comb begin
    if (func_q == hpa_pkg::FUNC_ALLOC) begin
      status_d = alloc_ok ? hpa_pkg::STATUS_OK : hpa_pkg::STATUS_EMPTY;
    end else begin
      status_d = rel_ok ? hpa_pkg::STATUS_OK : hpa_pkg::STATUS_BAD;
    end
    granted_d = alloc_ok ? hpa_pkg::HANDLE_W'(grant_idx) : '0;
  end

  // Ring memory with a registered read of the head entry.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && rel_ok) begin
      ring_q[tail_q] <= rel_idx;
    end
    rd_data_q    <= ring_q[head_q];
    rd_written_q <= written_q[head_q];
    rd_idx_q     <= head_q;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_req) begin
      func_q   <= func_i;
      handle_q <= handle_i;
    end
    if (cmd_i.commit) begin
      status_q  <= status_d;
      granted_q <= granted_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q    <= '0;
      tail_q    <= '0;
      count_q   <= CNT_W'(POOL_SIZE);
      active_q  <= '0;
      written_q <= '0;
    end else if (cmd_i.commit) begin
      if (alloc_ok) begin
        head_q              <= head_next;
        count_q             <= count_q - 1'b1;
        active_q[grant_idx] <= 1'b1;
      end else if (rel_ok) begin
        tail_q            <= tail_next;
        count_q           <= count_q + 1'b1;
        active_q[rel_idx] <= 1'b0;
        written_q[tail_q] <= 1'b1;
      end
    end
  end

  assign status_o         = status_q;
  assign granted_handle_o = granted_q;

endmodule

// ===== hdl/hpa_ctrl.sv =====
// Controller of the handle pool allocator: request sequencing and result valid.
module hpa_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output hpa_pkg::cmd_t cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q;
  logic   out_valid_q;
  logic   slot_free;

  // The result register is free when empty or being drained this cycle.
  assign slot_free = !out_valid_q || out_ready_i;

  assign in_ready_o      = (state_q == S_IDLE);
  assign cmd_o.load_req  = (state_q == S_IDLE) && in_valid_i;
  assign cmd_o.commit    = (state_q == S_EXEC) && slot_free;
  assign out_valid_o     = out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_EXEC;
          end
          if (out_ready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        S_EXEC: begin
          if (slot_free) begin
            state_q     <= S_IDLE;
            out_valid_q <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== hdl/handle_pool_allocator_unit.sv =====
// Top level of the handle pool allocator.
//
// The block hands out handles 0 to POOL_SIZE-1 from a FIFO free list. A
// request with func_i low allocates: the oldest free handle is returned on
// granted_handle_o with status 0, or status 1 comes back when the pool is
// empty. A request with func_i high releases handle_i: if that handle is
// currently handed out it goes to the tail of the free list and status 0 is
// returned, otherwise status 2 reports a bad handle and nothing changes.
// granted_handle_o is zero on every result that is not a successful
// allocate. Every request produces exactly one result transfer. The free
// ring is read at the head pointer on the same edge that captures the
// request. The controller then waits in its execute state until the
// result register is free, decides and updates the pool as it loads
// that register, and goes back to idle; only in idle can it take the
// next request. That request is taken as soon as the controller is back
// in idle, even while the previous result still waits in the output
// register; a stalled output only holds the block once a second result
// is ready. After reset the free list holds the handles in ascending
// order and no clearing pass is needed, so the block accepts a request
// as soon as reset is released.
module handle_pool_allocator_unit #(
  parameter int unsigned POOL_SIZE = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          func_i,
  input  logic [hpa_pkg::HANDLE_W-1:0]  handle_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [hpa_pkg::STATUS_W-1:0]  status_o,
  output logic [hpa_pkg::HANDLE_W-1:0]  granted_handle_o
);

  // Command bundle from the sequencer to the datapath.
  hpa_pkg::cmd_t cmd;

  // The controller decides when a request is captured and when its result
  // is committed; it also owns the valid flag of the result register.
  hpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // The datapath holds the free ring, its pointers and count, the bitmap of
  // handed-out handles and the result payload.
  hpa_datapath #(
    .POOL_SIZE (POOL_SIZE)
  ) u_datapath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .func_i           (func_i),
    .handle_i         (handle_i),
    .status_o         (status_o),
    .granted_handle_o (granted_handle_o)
  );

endmodule

// ===== hdl/hpa_checker.sv =====
// Port-level checker for the handle pool allocator, bound to the top level.
`include "handle_pool_allocator_unit_assert.svh"

module hpa_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          in_valid_i,
  input logic                          in_ready_o,
  input logic                          func_i,
  input logic [hpa_pkg::HANDLE_W-1:0]  handle_i,
  input logic                          out_valid_o,
  input logic                          out_ready_i,
  input logic [hpa_pkg::STATUS_W-1:0]  status_o,
  input logic [hpa_pkg::HANDLE_W-1:0]  granted_handle_o
);

  logic in_xfer;
  logic ok_status;
  logic not_ok;

  assign in_xfer   = in_valid_i && in_ready_o;
  assign not_ok    = out_valid_o && (status_o != hpa_pkg::STATUS_OK);
  assign ok_status = (status_o == hpa_pkg::STATUS_OK) ||
                     (status_o == hpa_pkg::STATUS_EMPTY) ||
                     (status_o == hpa_pkg::STATUS_BAD);

  `HPA_ASSERT_SAME(a_status_legal, out_valid_o, ok_status)
  `HPA_ASSERT_SAME(a_grant_zero, not_ok, granted_handle_o == '0)
  `HPA_ASSERT_NEXT(a_one_in_flight, in_xfer, !in_ready_o)
  `HPA_ASSERT_NEXT(a_out_hold, out_valid_o && !out_ready_i, out_valid_o && $stable(status_o))

endmodule

bind handle_pool_allocator_unit hpa_checker u_hpa_checker (.*);

// ===== bench/handle_pool_allocator_unit_tb.sv =====
// Self-checking testbench for the handle pool allocator with a scoreboard of pool replies.
`timescale 1ns / 1ps

module handle_pool_allocator_unit_tb;

  localparam int unsigned POOL_SIZE = 16;
  localparam int unsigned CLK_PERIOD = 20;
  // Longest correct quiet stretch is the output hold-off below plus a few
  // random gaps, so this leaves a wide margin.
  localparam int unsigned WATCHDOG_LIMIT = 2000;
  localparam int unsigned LONG_HOLD = 160;
  localparam int unsigned MAX_IDLE = 12;

  // One reply of the pool as the scoreboard expects it.
  typedef struct packed {
    logic [hpa_pkg::STATUS_W-1:0] status;
    logic [hpa_pkg::HANDLE_W-1:0] granted;
  } pool_reply_t;

  logic                         clk;
  logic                         rst_n;
  logic                         req_valid;
  logic                         req_func;
  logic [hpa_pkg::HANDLE_W-1:0] req_handle;
  logic                         rsp_ready;
  logic                         in_ready;
  logic                         out_valid;
  logic [hpa_pkg::STATUS_W-1:0] status;
  logic [hpa_pkg::HANDLE_W-1:0] granted_handle;

  // Private copy of the pool state that the predictor walks forward.
  logic [hpa_pkg::HANDLE_W-1:0] model_ring [POOL_SIZE];
  logic [hpa_pkg::HANDLE_W-1:0] model_head;
  logic [hpa_pkg::HANDLE_W-1:0] model_tail;
  logic [hpa_pkg::HANDLE_W:0]   model_free;
  logic [POOL_SIZE-1:0]         model_active;

  pool_reply_t pending_replies[$];
  int unsigned mismatch_count;
  int unsigned quiet_cycles;
  int unsigned hold_off_cycles;
  bit          burst_mode;

  handle_pool_allocator_unit #(
    .POOL_SIZE(POOL_SIZE)
  ) i_dut (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .in_valid_i      (req_valid),
    .in_ready_o      (in_ready),
    .func_i          (req_func),
    .handle_i        (req_handle),
    .out_valid_o     (out_valid),
    .out_ready_i     (rsp_ready),
    .status_o        (status),
    .granted_handle_o(granted_handle)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // Pool state right after reset: the ring holds every handle in ascending
  // order, the tail has wrapped onto the head and nothing is handed out.
  task automatic reset_pool_model();
    for (int i = 0; i < POOL_SIZE; i++) begin
      model_ring[i] = hpa_pkg::HANDLE_W'(i);
    end
    model_head   = '0;
    model_tail   = '0;
    model_free   = (hpa_pkg::HANDLE_W + 1)'(POOL_SIZE);
    model_active = '0;
  endtask

  // Applies one request to the private pool state and returns the reply.
  function automatic pool_reply_t serve_request(input logic func,
                                                input logic [hpa_pkg::HANDLE_W-1:0] handle);
    pool_reply_t reply;
    reply.status  = hpa_pkg::STATUS_OK;
    reply.granted = '0;
    if (func == hpa_pkg::FUNC_ALLOC) begin
      if (model_free == 0) begin
        reply.status = hpa_pkg::STATUS_EMPTY;
      end else begin
        reply.granted = model_ring[model_head];
        model_active[model_ring[model_head]] = 1'b1;
        model_head = model_head + 1'b1;
        model_free = model_free - 1'b1;
      end
    end else begin
      // Only a handle that is currently out may come back; anything else is
      // rejected and leaves the pool untouched.
      if (model_active[handle]) begin
        model_active[handle] = 1'b0;
        model_ring[model_tail] = handle;
        model_tail = model_tail + 1'b1;
        model_free = model_free + 1'b1;
      end else begin
        reply.status = hpa_pkg::STATUS_BAD;
      end
    end
    return reply;
  endfunction

  function automatic int unsigned draw_idle();
    return burst_mode ? 0 : $urandom_range(0, MAX_IDLE);
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("[%0t] mismatch: %s", $realtime, what);
  endtask

  // Offers one request and returns at the edge where its transfer happens.
  // Valid stays high across back-to-back requests when no gap is drawn.
  task automatic send_request(input logic func, input logic [hpa_pkg::HANDLE_W-1:0] handle);
    int unsigned gap;
    gap = draw_idle();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid  <= 1'b1;
    req_func   <= func;
    req_handle <= handle;
    do @(posedge clk); while (!in_ready);
    pending_replies.push_back(serve_request(func, handle));
  endtask

  // Sender goes quiet until the scoreboard holds nothing more.
  task automatic wait_for_replies();
    req_valid <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
  endtask

  // Sixteen allocates must hand out 0..15 in order, then the pool is empty.
  // The handle field is ignored on allocate, so its extremes ride along.
  task automatic test_exhaust_pool();
    for (int i = 0; i < POOL_SIZE; i++) begin
      send_request(hpa_pkg::FUNC_ALLOC, (i % 2) ? '1 : '0);
    end
    send_request(hpa_pkg::FUNC_ALLOC, '1);
  endtask

  // Good and bad releases, then reuse in the order the handles came back.
  task automatic test_release_cases();
    send_request(hpa_pkg::FUNC_RELEASE, '1);
    send_request(hpa_pkg::FUNC_RELEASE, '1);
    send_request(hpa_pkg::FUNC_RELEASE, '0);
    send_request(hpa_pkg::FUNC_ALLOC, '0);
    send_request(hpa_pkg::FUNC_ALLOC, '1);
    send_request(hpa_pkg::FUNC_ALLOC, '0);
    wait_for_replies();
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the
  // output register fills and the block has to stall its input.
  task automatic test_output_backpressure();
    wait_for_replies();
    burst_mode = 1'b1;
    hold_off_cycles = LONG_HOLD;
    for (int i = 0; i < 24; i++) begin
      send_request(i % 3 == 2 ? hpa_pkg::FUNC_RELEASE : hpa_pkg::FUNC_ALLOC,
                   hpa_pkg::HANDLE_W'($urandom));
    end
    wait_for_replies();
    burst_mode = 1'b0;
  endtask

  // Random traffic. Most releases name a handle that is out, so the ring
  // keeps wrapping; the rest are arbitrary handles and mostly bounce.
  task automatic test_random_traffic(input int unsigned n_items, input int unsigned alloc_pct);
    logic [hpa_pkg::HANDLE_W-1:0] handle;
    for (int n = 0; n < n_items; n++) begin
      handle = hpa_pkg::HANDLE_W'($urandom);
      if ($urandom_range(0, 99) < alloc_pct) begin
        send_request(hpa_pkg::FUNC_ALLOC, handle);
      end else begin
        if ($urandom_range(0, 9) < 7 && model_active != '0) begin
          while (!model_active[handle]) handle = hpa_pkg::HANDLE_W'($urandom);
        end
        send_request(hpa_pkg::FUNC_RELEASE, handle);
      end
    end
    wait_for_replies();
  endtask

  // Receiver: one drawn pause per result, or the long hold when requested.
  initial begin : reply_sink
    int unsigned pause;
    rsp_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (hold_off_cycles > 0) begin
        pause = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        pause = draw_idle();
      end
      if (pause > 0) begin
        rsp_ready <= 1'b0;
        repeat (pause) @(posedge clk);
      end
      rsp_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
    end
  end

  // Every result transfer is held against the oldest outstanding reply.
  always @(posedge clk) begin : check_replies
    pool_reply_t want;
    if (rst_n && out_valid && rsp_ready) begin
      if (pending_replies.size() == 0) begin
        report_mismatch($sformatf("result with nothing outstanding, status %0d handle %0d",
                                  status, granted_handle));
      end else begin
        want = pending_replies.pop_front();
        if (status !== want.status) begin
          report_mismatch($sformatf("status %0d, expected %0d", status, want.status));
        end
        if (granted_handle !== want.granted) begin
          report_mismatch($sformatf("granted handle %0d, expected %0d",
                                    granted_handle, want.granted));
        end
      end
    end
  end

  // Ends the run if neither channel moves a transfer for too long.
  always @(posedge clk) begin
    if (!rst_n || (req_valid && in_ready) || (out_valid && rsp_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst_n      <= 1'b0;
    req_valid  <= 1'b0;
    req_func   <= hpa_pkg::FUNC_ALLOC;
    req_handle <= '0;
    mismatch_count  = 0;
    quiet_cycles    = 0;
    hold_off_cycles = 0;
    burst_mode      = 1'b0;
    reset_pool_model();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    test_exhaust_pool();
    test_release_cases();
    test_output_backpressure();
    test_random_traffic(120, 50);
    burst_mode = 1'b1;
    test_random_traffic(120, 60);
    burst_mode = 1'b0;
    test_random_traffic(120, 35);
    test_random_traffic(120, 70);
    burst_mode = 1'b1;
    test_random_traffic(120, 45);
    burst_mode = 1'b0;

    // Leave room for any stray result before the verdict.
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
